>>> hdl/mca_pkg.sv
// Shared types, codes and constants for the MOESIF coherence agent.
package mca_pkg;

    localparam int ADDR_BITS = 32;
    localparam int ADDR_W    = 32;

    // Coherence states
    localparam logic [3:0] ST_I  = 4'd0;
    localparam logic [3:0] ST_S  = 4'd1;
    localparam logic [3:0] ST_E  = 4'd2;
    localparam logic [3:0] ST_M  = 4'd3;
    localparam logic [3:0] ST_F  = 4'd4;
    localparam logic [3:0] ST_O  = 4'd5;
    localparam logic [3:0] ST_IS = 4'd6;
    localparam logic [3:0] ST_IM = 4'd7;
    localparam logic [3:0] ST_SM = 4'd8;
    localparam logic [3:0] ST_EM = 4'd9;
    localparam logic [3:0] ST_FM = 4'd10;
    localparam logic [3:0] ST_OM = 4'd11;

    // Request keys: {mode, kind}
    localparam logic [3:0] KEY_LOAD     = 4'h0;
    localparam logic [3:0] KEY_STORE    = 4'h1;
    localparam logic [3:0] KEY_INV      = 4'h8;
    localparam logic [3:0] KEY_RECALL_I = 4'h9;
    localparam logic [3:0] KEY_RECALL_S = 4'hA;
    localparam logic [3:0] KEY_DATA     = 4'hB;
    localparam logic [3:0] KEY_DATA_E   = 4'hC;
    localparam logic [3:0] KEY_ACK      = 4'hD;

    // Sent messages
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_GETS    = 3'd1;
    localparam logic [2:0] ACT_GETM    = 3'd2;
    localparam logic [2:0] ACT_GETX    = 3'd3;
    localparam logic [2:0] ACT_DATA_P  = 3'd4;
    localparam logic [2:0] ACT_DATA_D  = 3'd5;
    localparam logic [2:0] ACT_INV_ACK = 3'd6;

    typedef struct packed {
        logic              mode;
        logic [2:0]        kind;
        logic [ADDR_W-1:0] block_address;
    } req_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [ADDR_W-1:0] out_address;
        logic              miss;
        logic              protocol_error;
        logic [3:0]        current_state;
    } rsp_t;

    typedef struct packed {
        logic       legal;
        logic [2:0] action;
        logic [3:0] next_state;
    } xlat_t;

endpackage

>>> hdl/mca_lookup.sv
// Next-state and outgoing-message lookup for the MOESIF coherence agent.
module mca_lookup (
    input  logic [3:0]     state,
    input  logic           mode,
    input  logic [2:0]     kind,
    output mca_pkg::xlat_t xlat
);
    import mca_pkg::*;

    logic [3:0] key;

    assign key = {mode, kind};

    always_comb begin
        xlat.legal      = 1'b1;
        xlat.action     = ACT_NONE;
        xlat.next_state = state;
        case (state)
            ST_I: begin
                case (key)
                    KEY_LOAD:  begin xlat.action = ACT_GETS; xlat.next_state = ST_IS; end
                    KEY_STORE: begin xlat.action = ACT_GETM; xlat.next_state = ST_IM; end
                    default:   xlat.legal = 1'b0;
                endcase
            end
            ST_S: begin
                case (key)
                    KEY_LOAD:  begin xlat.action = ACT_DATA_P;  xlat.next_state = ST_S;  end
                    KEY_STORE: begin xlat.action = ACT_GETM;    xlat.next_state = ST_SM; end
                    KEY_INV:   begin xlat.action = ACT_INV_ACK; xlat.next_state = ST_I;  end
                    default:   xlat.legal = 1'b0;
                endcase
            end
            ST_E: begin
                case (key)
                    KEY_LOAD:     begin xlat.action = ACT_DATA_P; xlat.next_state = ST_E;  end
                    KEY_STORE:    begin xlat.action = ACT_GETX;   xlat.next_state = ST_EM; end
                    KEY_RECALL_I: begin xlat.action = ACT_DATA_D; xlat.next_state = ST_I;  end
                    KEY_RECALL_S: begin xlat.action = ACT_DATA_D; xlat.next_state = ST_F;  end
                    default:      xlat.legal = 1'b0;
                endcase
            end
            ST_M: begin
                case (key)
                    KEY_LOAD, KEY_STORE: begin
                        xlat.action     = ACT_DATA_P;
                        xlat.next_state = ST_M;
                    end
                    KEY_RECALL_I: begin xlat.action = ACT_DATA_D; xlat.next_state = ST_I; end
                    KEY_RECALL_S: begin xlat.action = ACT_DATA_D; xlat.next_state = ST_O; end
                    default:      xlat.legal = 1'b0;
                endcase
            end
            ST_F, ST_O: begin
                case (key)
                    KEY_LOAD: begin xlat.action = ACT_DATA_P; xlat.next_state = state; end
                    KEY_STORE: begin
                        xlat.action     = ACT_GETM;
                        xlat.next_state = (state == ST_F) ? ST_FM : ST_OM;
                    end
                    KEY_RECALL_I: begin xlat.action = ACT_DATA_D; xlat.next_state = ST_I;  end
                    KEY_RECALL_S: begin xlat.action = ACT_DATA_D; xlat.next_state = state; end
                    default:      xlat.legal = 1'b0;
                endcase
            end
            ST_IS: begin
                case (key)
                    KEY_DATA:   begin xlat.action = ACT_DATA_P; xlat.next_state = ST_S; end
                    KEY_DATA_E: begin xlat.action = ACT_DATA_P; xlat.next_state = ST_E; end
                    default:    xlat.legal = 1'b0;
                endcase
            end
            ST_IM: begin
                case (key)
                    KEY_DATA: begin xlat.action = ACT_DATA_P; xlat.next_state = ST_M; end
                    default:  xlat.legal = 1'b0;
                endcase
            end
            ST_SM: begin
                case (key)
                    KEY_INV: begin xlat.action = ACT_INV_ACK; xlat.next_state = ST_IM; end
                    KEY_DATA, KEY_ACK: begin
                        xlat.action     = ACT_DATA_P;
                        xlat.next_state = ST_M;
                    end
                    default: xlat.legal = 1'b0;
                endcase
            end
            ST_EM, ST_FM, ST_OM: begin
                case (key)
                    KEY_RECALL_I: begin xlat.action = ACT_DATA_D; xlat.next_state = ST_IM; end
                    KEY_RECALL_S: begin
                        // owner keeps ownership, others fall back to forward
                        xlat.action     = ACT_DATA_D;
                        xlat.next_state = (state == ST_OM) ? ST_OM : ST_FM;
                    end
                    KEY_DATA, KEY_ACK: begin
                        xlat.action     = ACT_DATA_P;
                        xlat.next_state = ST_M;
                    end
                    default: xlat.legal = 1'b0;
                endcase
            end
            default: xlat.legal = 1'b0;
        endcase
        if (!xlat.legal) begin
            xlat.action     = ACT_NONE;
            xlat.next_state = state;
        end
    end

endmodule

>>> hdl/moesif_coherence_agent_core.sv
// Top level of the MOESIF coherence agent: state register, lookup and output buffer.
//
// Usage:
//   s_valid/s_ready/s_data carry one request transaction: a processor load or
//   store, or a network message, with its block address. m_valid/m_ready/m_data
//   carry one result transaction per request: the message sent, the address,
//   the miss and protocol error flags and the coherence state after the step.
//   Results are registered in the output or skid register. One request is
//   accepted every cycle while s_ready is high; the rate is set by the state
//   register, which is read and rewritten in the same cycle.
//   A two-entry output buffer (output register plus skid register) lets a
//   request be taken while a result waits; s_ready drops only when both hold
//   results, and rises again once the receiver takes one.
//   Reset (aresetn low, synchronous) puts the block in state I and empties the
//   output buffer. An illegal request gives a result with protocol_error set,
//   action none, address zero, and leaves the state unchanged.
//   ADDR_BITS keeps only the low bits of the address in the result.
module moesif_coherence_agent_core #(
    parameter int ADDR_BITS = mca_pkg::ADDR_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mca_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output mca_pkg::rsp_t m_data
);
    import mca_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ((ADDR_W'(1) << ADDR_BITS) - ADDR_W'(1));

    logic [3:0] state_reg, state_next;
    rsp_t       out_reg, out_next;
    logic       out_valid_reg, out_valid_next;
    rsp_t       skid_reg, skid_next;
    logic       skid_valid_reg, skid_valid_next;

    xlat_t xlat;
    rsp_t  rsp;
    logic  push, pop;

    mca_lookup u_lookup (
        .state (state_reg),
        .mode  (s_data.mode),
        .kind  (s_data.kind),
        .xlat  (xlat)
    );

    always_comb begin
        rsp.action         = xlat.action;
        rsp.out_address    = xlat.legal ? (s_data.block_address & ADDR_MASK) : '0;
        rsp.miss           = xlat.legal && (state_reg == ST_I);
        rsp.protocol_error = !xlat.legal;
        rsp.current_state  = xlat.next_state;
    end

    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign push    = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    always_comb begin
        state_next      = push ? xlat.next_state : state_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                // advance the held transaction
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else if (push) begin
                out_next = rsp;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_next       = rsp;
                skid_valid_next = 1'b1;
            end else begin
                out_next       = rsp;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_I;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a transaction while output register is empty");

    a_state_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg <= ST_OM)
        else $error("coherence state left the defined codes");

    a_error_no_action: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.protocol_error) |->
            (out_reg.action == ACT_NONE && !out_reg.miss))
        else $error("protocol error result carries a message or miss");

    a_state_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> (state_reg == $past(xlat.next_state)))
        else $error("state register did not take the looked-up state");

endmodule
